@@ hw/rtl/tpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpc_pkg: shared definitions for the trie prefix counter
// Default sizes, stream field widths, opcodes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

    // Default trie geometry.
    localparam int unsigned DEF_MAX_NODES     = 1024;
    localparam int unsigned DEF_ALPHABET_SIZE = 26;
    localparam int unsigned DEF_COUNT_BITS    = 16;

    // Stream field widths.
    localparam int unsigned LETTER_W       = 5;
    localparam int unsigned PREFIX_COUNT_W = 16;
    localparam int unsigned S_TDATA_W      = 8;
    localparam int unsigned S_TUSER_W      = 1;
    localparam int unsigned M_TDATA_W      = 16;
    localparam int unsigned M_TUSER_W      = 2;

    // Opcode carried in s_tuser.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } tpc_op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } tpc_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/tpc_ram.sv @@
// ----------------------------------------------------------------------------
// tpc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/trie_prefix_counter.sv @@
// ----------------------------------------------------------------------------
// trie_prefix_counter: prefix-count trie over a streamed alphabet
// Inserts and queries words one letter per request and reports prefix counts.
// ----------------------------------------------------------------------------
// Each letter request is taken in ST_IDLE, which reads the child slot of the
// current node from the slot memory, and ST_UPDATE writes the updated slot
// back; no new request is taken until that update commits, which for a last
// letter waits while the result register is full. Each slot holds both the
// child node index and that child's count, so a single read-modify-write per
// letter covers link and count. After reset the slot memory is swept to zero,
// one entry per cycle, over all MAX_NODES * ALPHABET_SIZE entries (26624 at
// the defaults); no request is taken until the sweep ends. A result is
// produced on each last letter and waits in an output register.
`default_nettype none

module trie_prefix_counter #(
    parameter int unsigned MAX_NODES     = tpc_pkg::DEF_MAX_NODES,
    parameter int unsigned ALPHABET_SIZE = tpc_pkg::DEF_ALPHABET_SIZE,
    parameter int unsigned COUNT_BITS    = tpc_pkg::DEF_COUNT_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tpc_pkg::S_TDATA_W-1:0]  s_tdata,   // [4:0] letter
    input  wire logic [tpc_pkg::S_TUSER_W-1:0]  s_tuser,   // [0] opcode
    input  wire logic                           s_tlast,   // last_letter
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [tpc_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] prefix_count
    output logic      [tpc_pkg::M_TUSER_W-1:0]  m_tuser    // [0] was_query, [1] pool_full
);

    import tpc_pkg::*;

    localparam int unsigned NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned FREE_W     = NODE_W + 1;
    localparam int unsigned LINK_DEPTH = MAX_NODES * ALPHABET_SIZE;
    localparam int unsigned ADDR_W     = $clog2(LINK_DEPTH);
    localparam int unsigned SLOT_W     = NODE_W + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [FREE_W-1:0]     FREE_LIMIT = FREE_W'(MAX_NODES);
    localparam logic [ADDR_W-1:0]     CLR_LAST   = ADDR_W'(LINK_DEPTH - 1);

    // Controller and walk state.
    tpc_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [FREE_W-1:0]   next_free_reg, next_free_next;
    logic                path_missing_reg, path_missing_next;
    logic                overflow_reg, overflow_next;

    // Request held for the update cycle.
    tpc_op_t             op_reg, op_next;
    logic [LETTER_W-1:0] letter_reg, letter_next;
    logic                last_reg, last_next;
    logic [ADDR_W-1:0]   slot_reg, slot_next;

    // Result register.
    logic                      m_valid_reg, m_valid_next;
    logic [PREFIX_COUNT_W-1:0] m_count_reg, m_count_next;
    logic                      m_query_reg, m_query_next;
    logic                      m_full_reg, m_full_next;

    // Slot memory ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;

    // Datapath helpers.
    logic                  accept;
    logic [LETTER_W-1:0]   in_letter;
    logic                  in_letter_ok;
    logic                  held_letter_ok;
    logic [NODE_W-1:0]     rd_child;
    logic [COUNT_BITS-1:0] rd_count;
    logic [COUNT_BITS-1:0] bumped_count;
    logic [COUNT_BITS-1:0] end_count;
    logic [31:0]           end_count_ext;
    logic                  pm_step;
    logic                  ov_step;
    logic                  out_free;
    logic                  commit;

    assign in_letter      = s_tdata[LETTER_W-1:0];
    assign in_letter_ok   = (32'(in_letter) < ALPHABET_SIZE);
    assign held_letter_ok = (32'(letter_reg) < ALPHABET_SIZE);
    assign accept         = s_tvalid && s_tready;
    assign rd_child       = ram_rdata[COUNT_BITS +: NODE_W];
    assign rd_count       = ram_rdata[COUNT_BITS-1:0];
    assign bumped_count   = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;
    assign out_free       = !m_valid_reg || m_tready;
    assign commit         = !last_reg || out_free;

    // Slot read address: cursor node row plus letter column.
    assign ram_re    = accept;
    assign ram_raddr = ADDR_W'(cursor_reg) * ADDR_W'(ALPHABET_SIZE)
                     + ADDR_W'(in_letter_ok ? in_letter : '0);

    // Slot memory: {child node, child count} per parent slot.
    tpc_ram #(
        .WIDTH  (SLOT_W),
        .DEPTH  (LINK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            cursor_reg       <= '0;
            next_free_reg    <= FREE_W'(1);
            path_missing_reg <= 1'b0;
            overflow_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            cursor_reg       <= cursor_next;
            next_free_reg    <= next_free_next;
            path_missing_reg <= path_missing_next;
            overflow_reg     <= overflow_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        letter_reg  <= letter_next;
        last_reg    <= last_next;
        slot_reg    <= slot_next;
        m_count_reg <= m_count_next;
        m_query_reg <= m_query_next;
        m_full_reg  <= m_full_next;
    end

    // Next state, memory writes and walk update.
    always_comb begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        cursor_next       = cursor_reg;
        next_free_next    = next_free_reg;
        path_missing_next = path_missing_reg;
        overflow_next     = overflow_reg;
        op_next           = op_reg;
        letter_next       = letter_reg;
        last_next         = last_reg;
        slot_next         = slot_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_count_next      = m_count_reg;
        m_query_next      = m_query_reg;
        m_full_next       = m_full_reg;
        s_tready          = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = slot_reg;
        ram_wdata         = '0;
        pm_step           = path_missing_reg;
        ov_step           = overflow_reg;
        end_count         = rd_count;
        end_count_ext     = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                // Sweep the slot memory to "no child, count zero".
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                // Take a letter and launch its slot read.
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next     = tpc_op_t'(s_tuser[0]);
                    letter_next = in_letter;
                    last_next   = s_tlast;
                    slot_next   = ram_raddr;
                    state_next  = ST_UPDATE;
                end
            end

            ST_UPDATE: begin
                if (commit) begin
                    // Follow or create the child link.
                    if (!path_missing_reg) begin
                        if (!held_letter_ok) begin
                            pm_step = 1'b1;
                        end else if (rd_child == '0) begin
                            if (op_reg == OP_QUERY) begin
                                pm_step = 1'b1;
                            end else if (next_free_reg >= FREE_LIMIT) begin
                                pm_step = 1'b1;
                                ov_step = 1'b1;
                            end else begin
                                ram_we         = 1'b1;
                                ram_wdata      = {next_free_reg[NODE_W-1:0],
                                                  COUNT_BITS'(1)};
                                cursor_next    = next_free_reg[NODE_W-1:0];
                                next_free_next = next_free_reg + 1'b1;
                                end_count      = COUNT_BITS'(1);
                            end
                        end else begin
                            cursor_next = rd_child;
                            if (op_reg == OP_INSERT) begin
                                ram_we    = 1'b1;
                                ram_wdata = {rd_child, bumped_count};
                                end_count = bumped_count;
                            end
                        end
                    end
                    path_missing_next = pm_step;
                    overflow_next     = ov_step;

                    // On the last letter, post the result and return to root.
                    if (last_reg) begin
                        end_count_ext     = pm_step ? '0 : 32'(end_count);
                        m_valid_next      = 1'b1;
                        m_count_next      = end_count_ext[PREFIX_COUNT_W-1:0];
                        m_query_next      = (op_reg == OP_QUERY);
                        m_full_next       = ov_step;
                        cursor_next       = '0;
                        path_missing_next = 1'b0;
                        overflow_next     = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_count_reg;
    assign m_tuser  = {m_full_reg, m_query_reg};

    // A slot write happens only during the sweep or an update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_UPDATE))
        else $error("slot write outside sweep or update");

    // An accepted letter is always followed by its update cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_UPDATE))
        else $error("accepted letter not followed by update");

    // The free-node pointer stays within the pool.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (next_free_reg >= FREE_W'(1)) && (next_free_reg <= FREE_LIMIT))
        else $error("free-node pointer out of range");

    // After a result is posted the walk is back at the root.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && last_reg && commit)
        |=> (cursor_reg == '0 && !path_missing_reg && !overflow_reg))
        else $error("walk not reset to root after result");

    // A pool-full result means the pool is really exhausted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_full_reg) |-> (next_free_reg == FREE_LIMIT))
        else $error("pool-full flag with free nodes left");

endmodule

`default_nettype wire

@@ sim/trie_prefix_counter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_prefix_counter_checker: result checker for the trie prefix counter
// Watches both stream channels, keeps its own copy of the trie, works out the
// result of every finished word and compares it with what the block returns.
// ----------------------------------------------------------------------------

module trie_prefix_counter_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [tpc_pkg::S_TDATA_W-1:0]       s_tdata,   // [4:0] letter
    input  logic [tpc_pkg::S_TUSER_W-1:0]       s_tuser,   // [0] opcode
    input  logic                                s_tlast,   // last_letter
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [tpc_pkg::M_TDATA_W-1:0]       m_tdata,   // [15:0] prefix_count
    input  logic [tpc_pkg::M_TUSER_W-1:0]       m_tuser,   // [0] was_query, [1] pool_full
    output int unsigned                         fail_count,
    output int unsigned                         results_owed
);
    import tpc_pkg::*;

    localparam int unsigned NODES     = DEF_MAX_NODES;
    localparam int unsigned ALPHA     = DEF_ALPHABET_SIZE;
    localparam int unsigned SLOTS     = NODES * ALPHA;
    localparam int unsigned NODE_W    = $clog2(NODES);
    localparam int unsigned PRINT_CAP = 100;

    typedef struct packed {
        logic [PREFIX_COUNT_W-1:0] prefix_count;
        logic                      was_query;
        logic                      pool_full;
    } word_result_t;

    // Shadow trie: child index per (node, letter) slot and a count per node.
    logic [NODE_W-1:0]         child_of  [0:SLOTS-1];
    logic [DEF_COUNT_BITS-1:0] word_hits [0:NODES-1];
    logic [NODE_W-1:0]         cursor;
    int unsigned               next_node;
    bit                        path_lost;
    bit                        pool_out;
    word_result_t              word_results [$];

    initial fail_count = 0;
    initial results_owed = 0;

    // One line per mismatch, with printing capped so a broken block stays readable.
    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_CAP) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        fail_count++;
    endtask

    // Move the cursor by one letter and, on the last letter, queue the word's result.
    task automatic walk_trie(input tpc_op_t op, input logic [LETTER_W-1:0] letter,
                             input logic last);
        int unsigned       slot;
        logic [NODE_W-1:0] child;
        word_result_t      res;
        if (!path_lost) begin
            if (letter >= ALPHA) begin
                path_lost = 1'b1;
            end else begin
                slot  = cursor * ALPHA + letter;
                child = child_of[slot];
                if (child == '0) begin
                    if (op == OP_QUERY) begin
                        path_lost = 1'b1;
                    end else if (next_node >= NODES) begin
                        pool_out  = 1'b1;
                        path_lost = 1'b1;
                    end else begin
                        child          = NODE_W'(next_node);
                        next_node++;
                        child_of[slot] = child;
                    end
                end
                if (!path_lost) begin
                    cursor = child;
                    if (op == OP_INSERT && word_hits[child] != '1) begin
                        word_hits[child] = word_hits[child] + 1'b1;
                    end
                end
            end
        end
        if (last) begin
            res.prefix_count = path_lost ? '0 : PREFIX_COUNT_W'(word_hits[cursor]);
            res.was_query    = (op == OP_QUERY);
            res.pool_full    = pool_out;
            word_results     = {word_results, res};
            cursor    = '0;
            path_lost = 1'b0;
            pool_out  = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        word_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) child_of[i] = '0;
            for (int i = 0; i < NODES; i++) word_hits[i] = '0;
            cursor    = '0;
            next_node = 1;
            path_lost = 1'b0;
            pool_out  = 1'b0;
            word_results.delete();
        end else begin
            // Returned results are checked before this edge's request is predicted.
            if (m_tvalid && m_tready) begin
                if (word_results.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: count %0d flags %b",
                                              m_tdata, m_tuser));
                end else begin
                    want = word_results.pop_front();
                    if (m_tdata[PREFIX_COUNT_W-1:0] !== want.prefix_count) begin
                        report_mismatch($sformatf("prefix_count %0d, expected %0d",
                                                  m_tdata, want.prefix_count));
                    end
                    if (m_tuser[0] !== want.was_query) begin
                        report_mismatch($sformatf("was_query %b, expected %b",
                                                  m_tuser[0], want.was_query));
                    end
                    if (m_tuser[1] !== want.pool_full) begin
                        report_mismatch($sformatf("pool_full %b, expected %b",
                                                  m_tuser[1], want.pool_full));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                walk_trie(tpc_op_t'(s_tuser[0]), s_tdata[LETTER_W-1:0], s_tlast);
            end
        end
        results_owed <= word_results.size();
    end

endmodule

@@ sim/trie_prefix_counter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_prefix_counter_tb: testbench for the trie prefix counter
// Streams hand-picked words and random words that share prefixes and exhaust
// the node pool, with random gaps and back-pressure. A separate checker
// predicts every result.
// ----------------------------------------------------------------------------

module trie_prefix_counter_tb;
    import tpc_pkg::*;

    // The limit allows for about 2000 requests, each with its work, the longest
    // sender gap and receiver stall, plus the slot sweep after reset and the long
    // hold-off, and lies above their total.
    localparam int unsigned LIMIT_CYCLES   = 200_000;
    localparam int unsigned RANDOM_ITEMS   = 2000;
    localparam int unsigned DEEP_TARGET    = 1100;
    localparam int unsigned HOLD_AFTER     = 300;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned TAIL_CYCLES    = 16;
    localparam int unsigned MAX_WORD       = 12;
    localparam int unsigned KEEP_WORDS     = 64;

    localparam logic [LETTER_W-1:0] LETTER_A  = 5'd0;
    localparam logic [LETTER_W-1:0] LETTER_B  = 5'd1;
    localparam logic [LETTER_W-1:0] LETTER_C  = 5'd2;
    localparam logic [LETTER_W-1:0] LETTER_Z  = 5'd25;
    localparam logic [LETTER_W-1:0] FIRST_BAD = 5'd26;
    localparam logic [LETTER_W-1:0] MID_BAD   = 5'd30;
    localparam logic [LETTER_W-1:0] LAST_BAD  = 5'd31;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int unsigned fail_count;
    int unsigned results_owed;
    int unsigned cycle_count = 0;

    // Idling controls shared by the sender and the receiver.
    bit          sender_bursty = 1'b1;
    bit          rx_steady     = 1'b0;
    bit          hold_req      = 1'b0;
    int unsigned burst_left    = 0;
    int unsigned items_sent    = 0;

    // Word under construction and a store of inserted words for later queries.
    tpc_op_t             op_buf       [0:MAX_WORD-1];
    logic [LETTER_W-1:0] letter_buf   [0:MAX_WORD-1];
    logic [LETTER_W-1:0] kept_letters [0:KEEP_WORDS-1][0:MAX_WORD-1];
    int unsigned         kept_len     [0:KEEP_WORDS-1];
    int unsigned         kept_count   = 0;

    trie_prefix_counter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    trie_prefix_counter_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("trie_prefix_counter_tb NOT OK");
            $finish;
        end
    end

    // Offer one letter request; in bursty mode, after a random gap when a burst has run out.
    task automatic offer_letter(input tpc_op_t op, input logic [LETTER_W-1:0] letter,
                                input logic last);
        int unsigned gap;
        if (sender_bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(16, 1);
                gap        = $urandom_range(8, 1);
                s_tvalid  <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left--;
        end
        s_tdata  <= S_TDATA_W'(letter);
        s_tuser  <= op;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Send the word held in the buffers, marking its final letter.
    task automatic send_buffer(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            offer_letter(op_buf[i], letter_buf[i], i == len - 1);
        end
    endtask

    // Receiver: random ready pattern, steady stretches, and one long hold-off.
    initial begin : receiver
        int unsigned run;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_steady) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                run = $urandom_range(12, 1);
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
                run = $urandom_range(4, 1);
                m_tready <= 1'b0;
                repeat (run) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int unsigned random_start;
        int unsigned deep_letters;
        int unsigned pick;
        int unsigned ins_share;
        int unsigned qry_share;
        int unsigned mix_share;
        int unsigned len;
        int unsigned slot;
        int unsigned segment;
        bit          wide;
        bit          hold_done;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words: empty trie, shared prefixes, alphabet edges,
        // out-of-range letters, missing paths and mixed opcodes.
        offer_letter(OP_QUERY,  LETTER_A,  1'b1);
        offer_letter(OP_INSERT, LETTER_A,  1'b1);
        offer_letter(OP_INSERT, LETTER_A,  1'b0);
        offer_letter(OP_INSERT, LETTER_B,  1'b1);
        offer_letter(OP_QUERY,  LETTER_A,  1'b1);
        offer_letter(OP_QUERY,  LETTER_A,  1'b0);
        offer_letter(OP_QUERY,  LETTER_B,  1'b1);
        offer_letter(OP_INSERT, LETTER_Z,  1'b1);
        offer_letter(OP_QUERY,  LETTER_Z,  1'b0);
        offer_letter(OP_QUERY,  LETTER_Z,  1'b1);
        offer_letter(OP_INSERT, LAST_BAD,  1'b1);
        offer_letter(OP_QUERY,  FIRST_BAD, 1'b1);
        offer_letter(OP_INSERT, LETTER_A,  1'b0);
        offer_letter(OP_INSERT, MID_BAD,   1'b0);
        offer_letter(OP_INSERT, LETTER_B,  1'b1);
        offer_letter(OP_INSERT, LETTER_A,  1'b0);
        offer_letter(OP_QUERY,  LETTER_B,  1'b1);
        offer_letter(OP_QUERY,  LETTER_A,  1'b0);
        offer_letter(OP_INSERT, LETTER_C,  1'b1);
        offer_letter(OP_QUERY,  LETTER_A,  1'b1);

        // Random words. Inserts lean on long words over the full alphabet until
        // the pool is surely exhausted; queries mostly follow stored words.
        random_start = items_sent;
        deep_letters = 0;
        hold_done    = 1'b0;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            segment       = (items_sent - random_start) / 256;
            sender_bursty = (segment % 4 != 1);
            rx_steady     = (segment % 4 == 2);
            if (!hold_done && items_sent - random_start >= HOLD_AFTER) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end

            ins_share = (deep_letters < DEEP_TARGET) ? 70 : 40;
            qry_share = (deep_letters < DEEP_TARGET) ? 20 : 35;
            mix_share = (deep_letters < DEEP_TARGET) ? 6 : 15;
            pick      = $urandom_range(99);

            if (pick < ins_share) begin
                wide = ($urandom_range(3) != 0);
                len  = wide ? $urandom_range(MAX_WORD, 8) : $urandom_range(MAX_WORD, 1);
                for (int unsigned i = 0; i < len; i++) begin
                    op_buf[i]     = OP_INSERT;
                    letter_buf[i] = wide ? LETTER_W'($urandom_range(25))
                                         : LETTER_W'($urandom_range(2));
                end
                if (wide) deep_letters += len - 2;
                if (kept_count < KEEP_WORDS) begin
                    slot = kept_count;
                    kept_count++;
                end else begin
                    slot = $urandom_range(KEEP_WORDS - 1);
                end
                for (int unsigned i = 0; i < len; i++) kept_letters[slot][i] = letter_buf[i];
                kept_len[slot] = len;
            end else if (pick < ins_share + qry_share) begin
                if (kept_count != 0 && $urandom_range(9) < 7) begin
                    slot = $urandom_range(kept_count - 1);
                    len  = $urandom_range(kept_len[slot], 1);
                    for (int unsigned i = 0; i < len; i++) letter_buf[i] = kept_letters[slot][i];
                end else begin
                    len = $urandom_range(6, 1);
                    for (int unsigned i = 0; i < len; i++) begin
                        letter_buf[i] = LETTER_W'($urandom_range(2));
                    end
                end
                for (int unsigned i = 0; i < len; i++) op_buf[i] = OP_QUERY;
            end else if (pick < ins_share + qry_share + mix_share) begin
                // Opcodes change letter by letter within the word.
                len = $urandom_range(6, 1);
                for (int unsigned i = 0; i < len; i++) begin
                    op_buf[i]     = tpc_op_t'($urandom_range(1));
                    letter_buf[i] = LETTER_W'($urandom_range(2));
                end
            end else begin
                // Noise: any letter code, any opcode.
                len = $urandom_range(4, 1);
                for (int unsigned i = 0; i < len; i++) begin
                    op_buf[i]     = tpc_op_t'($urandom_range(1));
                    letter_buf[i] = LETTER_W'($urandom_range(31));
                end
            end

            // Now and then a letter outside the alphabet breaks the word.
            if ($urandom_range(49) == 0) begin
                letter_buf[$urandom_range(len - 1)] =
                    LETTER_W'($urandom_range(LAST_BAD, FIRST_BAD));
            end
            send_buffer(len);
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then allow for stray late ones.
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("trie_prefix_counter_tb OK");
        end else begin
            $display("trie_prefix_counter_tb NOT OK");
        end
        $finish;
    end

endmodule
